// ----- hw/rtl/mgfb_pkg.sv -----
package mgfb_pkg;

  localparam int TAG_W      = 16;
  localparam int PTS_W      = 48;
  localparam int INTERVAL_W = 32;
  localparam int PROP_W     = 32;
  localparam int LIMIT_W    = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [PROP_W-1:0]  PROP_RESET  = 32'd1000000000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd20;
  localparam logic               FWD_RESET   = 1'b1;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_FLUSH = 1'b1
  } mgfb_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROPAGATION_TIME = 2'd0,
    REG_BUFFER_LIMIT     = 2'd1,
    REG_FORWARD_ENABLE   = 2'd2
  } mgfb_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_EVAL
  } mgfb_state_t;

  typedef struct packed {
    mgfb_kind_t              kind;
    logic [TAG_W-1:0]        tag;
    logic [PTS_W-1:0]        pts;
    logic [INTERVAL_W-1:0]   interval;
    logic                    motion;
  } mgfb_cmd_t;

  typedef struct packed {
    logic [PROP_W-1:0]  propagation_time;
    logic [LIMIT_W-1:0] buffer_limit;
    logic               forward_enable;
  } mgfb_cfg_t;

endpackage

// ----- hw/rtl/mgfb_ram.sv -----
module mgfb_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mgfb_front.sv -----
module mgfb_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [mgfb_pkg::TAG_W-1:0]         frame_tag,
  input  logic [mgfb_pkg::PTS_W-1:0]         frame_pts,
  input  logic [mgfb_pkg::INTERVAL_W-1:0]    frame_interval,
  input  logic                               motion_seen,
  output logic                               cmd_valid,
  output mgfb_pkg::mgfb_cmd_t                cmd,
  input  logic                               cmd_take
);

  // two-entry command queue between intake and the engine
  mgfb_pkg::mgfb_cmd_t slot [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                accept;
  mgfb_pkg::mgfb_cmd_t incoming;

  assign in_stall  = (count == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_comb begin
    incoming.kind     = kind ? mgfb_pkg::CMD_FLUSH : mgfb_pkg::CMD_FRAME;
    incoming.tag      = frame_tag;
    incoming.pts      = frame_pts;
    incoming.interval = frame_interval;
    incoming.motion   = motion_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, cmd_take};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= incoming;
    end
  end

endmodule

// ----- hw/rtl/mgfb_back.sv -----
module mgfb_back #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mgfb_pkg::mgfb_cfg_t             cfg,
  input  logic                            cmd_valid,
  input  mgfb_pkg::mgfb_cmd_t             cmd,
  output logic                            cmd_take,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mgfb_pkg::TAG_W-1:0]      out_tag,
  output logic                            forwarded,
  output logic [mgfb_pkg::PTS_W-1:0]      out_pts,
  output logic [mgfb_pkg::PTS_W-1:0]      real_pts,
  output logic                            last
);

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W   = (FILL_W > mgfb_pkg::LIMIT_W) ? FILL_W : mgfb_pkg::LIMIT_W;
  localparam int SUM_W   = FILL_W + 1;
  localparam int ENTRY_W = mgfb_pkg::TAG_W + TIME_BITS + mgfb_pkg::INTERVAL_W;

  typedef struct packed {
    logic [mgfb_pkg::TAG_W-1:0]      tag;
    logic [TIME_BITS-1:0]            pts;
    logic [mgfb_pkg::INTERVAL_W-1:0] interval;
  } entry_t;

  mgfb_pkg::mgfb_state_t state, state_next;
  logic [ADDR_W-1:0]     head, head_next;
  logic [FILL_W-1:0]     fill, fill_next;
  logic [TIME_BITS-1:0]  newest, newest_next;
  logic [TIME_BITS-1:0]  last_motion, last_motion_next;
  logic [TIME_BITS-1:0]  out_time, out_time_next;
  mgfb_pkg::mgfb_cmd_t   cur, cur_next;
  logic                  had_items, had_items_next;

  // popped result whose last flag is not known until the next decision
  logic                         pend_valid, pend_valid_next;
  logic [mgfb_pkg::TAG_W-1:0]   pend_tag, pend_tag_next;
  logic                         pend_fwd, pend_fwd_next;
  logic [mgfb_pkg::PTS_W-1:0]   pend_opts, pend_opts_next;
  logic [mgfb_pkg::PTS_W-1:0]   pend_rpts, pend_rpts_next;

  logic                         out_valid_next;
  logic [mgfb_pkg::TAG_W-1:0]   out_tag_next;
  logic                         forwarded_next;
  logic [mgfb_pkg::PTS_W-1:0]   out_pts_next;
  logic [mgfb_pkg::PTS_W-1:0]   real_pts_next;
  logic                         last_next;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  entry_t                ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                head_entry;

  logic [TIME_BITS-1:0]  ht;
  logic [TIME_BITS-1:0]  prop;
  logic [LIM_W-1:0]      limit_req;
  logic [LIM_W-1:0]      limit;
  logic                  too_many;
  logic                  expired;
  logic                  propagated;
  logic                  has_motion;
  logic                  is_flush;
  logic                  pop;
  logic                  fwd;
  logic [TIME_BITS-1:0]  out_time_adv;
  logic                  out_free;
  logic [ADDR_W-1:0]     head_inc;
  logic [SUM_W-1:0]      slot_sum;
  logic [ADDR_W-1:0]     push_slot;

  mgfb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(head_next),
    .rdata(ram_rdata)
  );

  assign head_entry = entry_t'(ram_rdata);
  assign ht         = head_entry.pts;
  assign prop       = TIME_BITS'(cfg.propagation_time);

  always_comb begin
    limit_req  = LIM_W'(cfg.buffer_limit);
    limit      = (limit_req > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH) : limit_req;
    too_many   = (LIM_W'(fill) >= limit);
    expired    = (newest > ht) && ((newest - ht) > prop);
    propagated = (ht <= last_motion) || ((ht - last_motion) <= prop);
    has_motion = propagated || (!expired && cur.motion);
    is_flush   = (cur.kind == mgfb_pkg::CMD_FLUSH);
    pop        = (fill != '0) && (is_flush || has_motion || expired || too_many);
    fwd        = !is_flush && has_motion && cfg.forward_enable;
    out_time_adv = (out_time == '0) ? ht
                                    : out_time + TIME_BITS'(head_entry.interval);
    out_free   = !out_valid || !out_stall;
    head_inc   = (head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    slot_sum   = SUM_W'(head) + SUM_W'(fill);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
    end
    push_slot  = slot_sum[ADDR_W-1:0];
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    fill_next        = fill;
    newest_next      = newest;
    last_motion_next = last_motion;
    out_time_next    = out_time;
    cur_next         = cur;
    had_items_next   = had_items;
    pend_valid_next  = pend_valid;
    pend_tag_next    = pend_tag;
    pend_fwd_next    = pend_fwd;
    pend_opts_next   = pend_opts;
    pend_rpts_next   = pend_rpts;
    out_valid_next   = out_valid && out_stall;
    out_tag_next     = out_tag;
    forwarded_next   = forwarded;
    out_pts_next     = out_pts;
    real_pts_next    = real_pts;
    last_next        = last;
    cmd_take         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = push_slot;
    ram_wdata.tag      = cur.tag;
    ram_wdata.pts      = TIME_BITS'(cur.pts);
    ram_wdata.interval = cur.interval;

    unique case (state)
      mgfb_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_take       = 1'b1;
          cur_next       = cmd;
          had_items_next = (fill != '0);
          state_next     = mgfb_pkg::BK_LOAD;
        end
      end
      mgfb_pkg::BK_LOAD: begin
        // read of the head entry is in flight
        state_next = mgfb_pkg::BK_EVAL;
      end
      mgfb_pkg::BK_EVAL: begin
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_tag_next   = pend_tag;
            forwarded_next = pend_fwd;
            out_pts_next   = pend_opts;
            real_pts_next  = pend_rpts;
            last_next      = !pop;
          end
          if (pop) begin
            pend_valid_next = 1'b1;
            pend_tag_next   = head_entry.tag;
            pend_fwd_next   = fwd;
            pend_opts_next  = fwd ? mgfb_pkg::PTS_W'(out_time_adv) : mgfb_pkg::PTS_W'(ht);
            pend_rpts_next  = mgfb_pkg::PTS_W'(ht);
            if (fwd) begin
              out_time_next = out_time_adv;
            end
            head_next = head_inc;
            fill_next = fill - 1'b1;
          end else begin
            pend_valid_next = 1'b0;
            if (is_flush) begin
              head_next        = '0;
              last_motion_next = '0;
              out_time_next    = '0;
            end else begin
              if (had_items && cur.motion) begin
                last_motion_next = newest;
              end
              ram_we      = 1'b1;
              fill_next   = fill + 1'b1;
              newest_next = TIME_BITS'(cur.pts);
            end
            state_next = mgfb_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_next = mgfb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mgfb_pkg::BK_IDLE;
      head        <= '0;
      fill        <= '0;
      last_motion <= '0;
      out_time    <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      fill        <= fill_next;
      last_motion <= last_motion_next;
      out_time    <= out_time_next;
      pend_valid  <= pend_valid_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    newest    <= newest_next;
    cur       <= cur_next;
    had_items <= had_items_next;
    pend_tag  <= pend_tag_next;
    pend_fwd  <= pend_fwd_next;
    pend_opts <= pend_opts_next;
    pend_rpts <= pend_rpts_next;
    out_tag   <= out_tag_next;
    forwarded <= forwarded_next;
    out_pts   <= out_pts_next;
    real_pts  <= real_pts_next;
    last      <= last_next;
  end

endmodule

// ----- hw/rtl/motion_gated_frame_buffer.sv -----
// Pre-record buffer for motion-triggered capture.
//
// Input channel (in_valid / in_stall): one word per frame or reset request.
// A frame word first releases head frames while they carry spread motion,
// have expired, or the queue stands at its limit, and is then queued with its
// timestamp and interval. A reset word releases all buffered frames as dropped.
// Output channel (out_valid / out_stall): one word per released frame, oldest
// first, with last set on the final word of an input word. An input word that
// releases nothing yields no output word.
// The engine takes an input word while idle, reads the head entry in its load
// state, and in its evaluate state moves each released frame to a pending
// register, then to the output register once the next decision sets its last
// flag. An input word releases at most 32 frames at a depth of 32; the single
// read port of the frame store gives one entry per cycle unless output stalls.
// A two-word command queue takes new words while the engine is busy, and the
// output register holds a word while the engine prepares the next.
// Reset (rst, synchronous): the queue empties, both times clear and the
// registers return to their defaults. The frame store is not cleared.
// A stalled receiver freezes the output word; the engine holds and the
// input side stalls once the command queue is full.
module motion_gated_frame_buffer #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mgfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mgfb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [mgfb_pkg::TAG_W-1:0]         frame_tag,
  input  logic [mgfb_pkg::PTS_W-1:0]         frame_pts,
  input  logic [mgfb_pkg::INTERVAL_W-1:0]    frame_interval,
  input  logic                               motion_seen,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mgfb_pkg::TAG_W-1:0]         out_tag,
  output logic                               forwarded,
  output logic [mgfb_pkg::PTS_W-1:0]         out_pts,
  output logic [mgfb_pkg::PTS_W-1:0]         real_pts,
  output logic                               last
);

  mgfb_pkg::mgfb_cfg_t cfg;
  logic                cmd_valid;
  logic                cmd_take;
  mgfb_pkg::mgfb_cmd_t cmd;

  // configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.propagation_time <= mgfb_pkg::PROP_RESET;
      cfg.buffer_limit     <= mgfb_pkg::LIMIT_RESET;
      cfg.forward_enable   <= mgfb_pkg::FWD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mgfb_pkg::REG_PROPAGATION_TIME: begin
          cfg.propagation_time <= cfg_data[mgfb_pkg::PROP_W-1:0];
        end
        mgfb_pkg::REG_BUFFER_LIMIT: begin
          cfg.buffer_limit <= cfg_data[mgfb_pkg::LIMIT_W-1:0];
        end
        mgfb_pkg::REG_FORWARD_ENABLE: begin
          cfg.forward_enable <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // intake: classify each word and hold it for the engine
  mgfb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .frame_tag     (frame_tag),
    .frame_pts     (frame_pts),
    .frame_interval(frame_interval),
    .motion_seen   (motion_seen),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  // engine: walk the head of the frame store, release, then queue the frame
  mgfb_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tag  (out_tag),
    .forwarded(forwarded),
    .out_pts  (out_pts),
    .real_pts (real_pts),
    .last     (last)
  );

endmodule

// ----- hw/rtl/mgfb_checker.sv -----
module mgfb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [mgfb_pkg::TAG_W-1:0]      out_tag,
  input logic                            forwarded,
  input logic [mgfb_pkg::PTS_W-1:0]      out_pts,
  input logic [mgfb_pkg::PTS_W-1:0]      real_pts,
  input logic                            last
);

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // reset empties the command queue
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // a dropped frame keeps its own timestamp
  a_drop_pts: assert property (@(posedge clk) disable iff (rst)
    out_valid && !forwarded |-> out_pts == real_pts)
    else $error("dropped frame with altered timestamp");

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_tag) && $stable(last)
      && $stable(out_pts) && $stable(forwarded))
    else $error("stalled output word changed");

endmodule

bind motion_gated_frame_buffer mgfb_checker u_mgfb_checker (.*);
